@@ rtl/core/char_lcd_frame_serializer_assert.svh @@
// Assertion macros shared by the framebuffer serializer modules.
`ifndef CHAR_LCD_FRAME_SERIALIZER_ASSERT_SVH
`define CHAR_LCD_FRAME_SERIALIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define CLFS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
`define CLFS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define CLFS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define CLFS_ASSERT(lbl, ck, rs, prop, msg)
`define CLFS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg)
`define CLFS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

@@ rtl/core/clfs_pkg.sv @@
`default_nettype none
package clfs_pkg;

  localparam logic [7:0] BLANK_CODE = 8'h20;
  localparam logic [7:0] ESC_CODE   = 8'h1B;
  localparam logic [7:0] ESC_BELOW  = 8'h08;
  localparam logic [7:0] HOME_CODE  = 8'h1E;
  localparam logic [7:0] LF_CODE    = 8'h0A;
  localparam logic [7:0] CR_CODE    = 8'h0D;

  localparam int S_DATA_W = 24;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 8;
  localparam int CFG_W    = 5;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  localparam logic REG_COLS_IN_USE = 1'b0;
  localparam logic REG_ROWS_IN_USE = 1'b1;

  localparam logic [4:0] COLS_RESET = 5'd16;
  localparam logic [2:0] ROWS_RESET = 3'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_HOME,
    ST_RD,
    ST_DATA,
    ST_ESC,
    ST_CHAR,
    ST_LF,
    ST_CR
  } state_t;

  typedef struct packed {
    logic frame_clear;
    logic frame_we;
    logic frame_re;
    logic shadow_we;
    logic shadow_re;
  } mem_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/clfs_cell_mem.sv @@
`default_nettype none
`include "char_lcd_frame_serializer_assert.svh"
module clfs_cell_mem #(
  parameter int DEPTH  = 80,
  parameter int ADDR_W = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear_all,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // A cell that was never written since reset or the last clear reads as a blank.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : clfs_pkg::BLANK_CODE;
    end
  end

  `CLFS_ASSERT_IMPL(a_no_rw_same, clk, rst, re && we, raddr != waddr, "read and write hit one cell")
  `CLFS_ASSERT_IMPL(a_clear_alone, clk, rst, clear_all, !we, "clear coincides with a write")
  `CLFS_ASSERT_NEXT(a_write_marks, clk, rst, we, valid[$past(waddr)], "written cell not marked")

endmodule
`default_nettype wire

@@ rtl/core/clfs_ctrl.sv @@
`default_nettype none
`include "char_lcd_frame_serializer_assert.svh"
module clfs_ctrl #(
  parameter int MAX_COLS = 20,
  parameter int ADDR_W   = 7,
  parameter int COL_W    = 5,
  parameter int ROW_W    = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [clfs_pkg::S_DATA_W-1:0]   s_tdata,
  input  wire logic [clfs_pkg::S_USER_W-1:0]   s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [clfs_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                                 m_tlast,
  input  wire logic [COL_W-1:0]                last_col,
  input  wire logic [ROW_W-1:0]                last_row,
  output clfs_pkg::mem_ctl_t                   mem_ctl,
  output logic      [ADDR_W-1:0]               frame_waddr,
  output logic      [7:0]                      frame_wdata,
  output logic      [ADDR_W-1:0]               rd_addr,
  input  wire logic [7:0]                      frame_rdata,
  input  wire logic [7:0]                      shadow_rdata
);

  clfs_pkg::state_t state, state_next;

  logic [1:0]        req_type;
  logic [5:0]        col_pos;
  logic [3:0]        line_pos;
  logic [7:0]        char_code;
  logic              in_fire;
  logic              col_ok;
  logic              row_ok;
  logic              out_free;
  logic              out_load;
  logic [7:0]        out_byte_next;
  logic              out_last_next;
  logic              col_last;
  logic              row_last;
  logic              mismatch;
  logic              pass_skipped;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row_cnt;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] flush_base;

  assign req_type  = s_tuser;
  assign col_pos   = s_tdata[5:0];
  assign line_pos  = s_tdata[9:6];
  assign char_code = s_tdata[17:10];

  assign s_tready = (state == clfs_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign col_ok   = (col_pos != 6'd0) && (32'(col_pos) <= 32'(last_col) + 32'd1);
  assign row_ok   = (line_pos != 4'd0) && (32'(line_pos) <= 32'(last_row) + 32'd1);
  assign out_free = !m_tvalid || m_tready;
  assign col_last = (col == last_col);
  assign row_last = (row_cnt == last_row);
  assign mismatch = (frame_rdata != shadow_rdata);

  assign flush_base  = ADDR_W'((32'(line_pos) - 32'd1) * MAX_COLS);
  assign frame_waddr = ADDR_W'((32'(line_pos) - 32'd1) * MAX_COLS + 32'(col_pos) - 32'd1);
  assign frame_wdata = char_code;
  assign rd_addr     = ADDR_W'(32'(base) + 32'(col));

  always_comb begin
    state_next = state;
    unique case (state)
      clfs_pkg::ST_IDLE: begin
        if (in_fire && req_type == clfs_pkg::REQ_FLUSH && row_ok) begin
          if (line_pos == 4'd1) begin
            state_next = clfs_pkg::ST_CMP_RD;
          end else if (!pass_skipped) begin
            state_next = clfs_pkg::ST_RD;
          end
        end
      end
      clfs_pkg::ST_CMP_RD:  state_next = clfs_pkg::ST_CMP_CHK;
      clfs_pkg::ST_CMP_CHK: begin
        if (mismatch) begin
          state_next = clfs_pkg::ST_HOME;
        end else if (col_last && row_last) begin
          state_next = clfs_pkg::ST_IDLE;
        end else begin
          state_next = clfs_pkg::ST_CMP_RD;
        end
      end
      clfs_pkg::ST_HOME: if (out_free) state_next = clfs_pkg::ST_RD;
      clfs_pkg::ST_RD:   state_next = clfs_pkg::ST_DATA;
      clfs_pkg::ST_DATA: begin
        state_next = (frame_rdata < clfs_pkg::ESC_BELOW) ? clfs_pkg::ST_ESC : clfs_pkg::ST_CHAR;
      end
      clfs_pkg::ST_ESC:  if (out_free) state_next = clfs_pkg::ST_CHAR;
      clfs_pkg::ST_CHAR: begin
        if (out_free) state_next = col_last ? clfs_pkg::ST_LF : clfs_pkg::ST_RD;
      end
      clfs_pkg::ST_LF:   if (out_free) state_next = clfs_pkg::ST_CR;
      clfs_pkg::ST_CR:   if (out_free) state_next = clfs_pkg::ST_IDLE;
      default:           state_next = clfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_load      = 1'b0;
    out_byte_next = clfs_pkg::HOME_CODE;
    out_last_next = 1'b0;
    mem_ctl       = '0;
    unique case (state)
      clfs_pkg::ST_IDLE: begin
        mem_ctl.frame_we    = in_fire && req_type == clfs_pkg::REQ_WRITE && col_ok && row_ok;
        mem_ctl.frame_clear = in_fire && req_type == clfs_pkg::REQ_CLEAR;
      end
      clfs_pkg::ST_CMP_RD: begin
        mem_ctl.frame_re  = 1'b1;
        mem_ctl.shadow_re = 1'b1;
      end
      clfs_pkg::ST_HOME: out_load = out_free;
      clfs_pkg::ST_RD:   mem_ctl.frame_re = 1'b1;
      // The cell just read goes to the shadow at the same address.
      clfs_pkg::ST_DATA: mem_ctl.shadow_we = 1'b1;
      clfs_pkg::ST_ESC: begin
        out_load      = out_free;
        out_byte_next = clfs_pkg::ESC_CODE;
      end
      clfs_pkg::ST_CHAR: begin
        out_load      = out_free;
        out_byte_next = frame_rdata;
      end
      clfs_pkg::ST_LF: begin
        out_load      = out_free;
        out_byte_next = clfs_pkg::LF_CODE;
      end
      clfs_pkg::ST_CR: begin
        out_load      = out_free;
        out_byte_next = clfs_pkg::CR_CODE;
        out_last_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= clfs_pkg::ST_IDLE;
      pass_skipped <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == clfs_pkg::ST_CMP_CHK) begin
        if (mismatch) begin
          pass_skipped <= 1'b0;
        end else if (col_last && row_last) begin
          pass_skipped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_byte_next;
      m_tlast <= out_last_next;
    end
    if (state == clfs_pkg::ST_IDLE && in_fire) begin
      col     <= '0;
      row_cnt <= '0;
      base    <= flush_base;
    end else if (state == clfs_pkg::ST_CMP_CHK) begin
      // A difference anywhere restarts the walk at row 1 for sending.
      if (mismatch) begin
        base <= '0;
        col  <= '0;
      end else if (col_last) begin
        if (!row_last) begin
          row_cnt <= row_cnt + 1'b1;
          base    <= ADDR_W'(32'(base) + MAX_COLS);
          col     <= '0;
        end
      end else begin
        col <= col + 1'b1;
      end
    end else if (state == clfs_pkg::ST_CHAR && out_free && !col_last) begin
      col <= col + 1'b1;
    end
  end

  `CLFS_ASSERT_IMPL(a_shadow_after_read, clk, rst, mem_ctl.shadow_we, $past(state) == clfs_pkg::ST_RD, "shadow written without a frame read")
  `CLFS_ASSERT_IMPL(a_tlast_is_cr, clk, rst, m_tvalid && m_tlast, m_tdata == clfs_pkg::CR_CODE, "last byte is not a carriage return")
  `CLFS_ASSERT_NEXT(a_equal_sets_skip, clk, rst, state == clfs_pkg::ST_CMP_CHK && !mismatch && col_last && row_last, pass_skipped, "unchanged frame did not mark the pass")
  `CLFS_ASSERT_IMPL(a_home_from_cmp, clk, rst, state == clfs_pkg::ST_HOME && $past(state) != clfs_pkg::ST_HOME, $past(state) == clfs_pkg::ST_CMP_CHK, "cursor home without a compare")

endmodule
`default_nettype wire

@@ rtl/core/char_lcd_frame_serializer.sv @@
// Write and clear requests leave the block idle, so it stays ready for the next one.
// A flush of row 1 first walks the used frame against the shadow, cell by cell.
// Sending a row walks each cell through memory read, data and byte, with an escape
// byte first below ESC_BELOW, then line feed and carriage return; home leads after a
// compare; a stalled output holds the bytes. Reset makes both stores read as blanks.
`default_nettype none
module char_lcd_frame_serializer #(
  parameter int MAX_COLS = 20,
  parameter int MAX_ROWS = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [clfs_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // col_pos [5:0], line_pos [9:6], char_code [17:10], zero fill above
  input  wire logic [clfs_pkg::S_DATA_W-1:0]  s_tdata,
  // req_type [1:0]
  input  wire logic [clfs_pkg::S_USER_W-1:0]  s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // out_byte [7:0]
  output logic      [clfs_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                                m_tlast
);

  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [4:0]         cols_in_use;
  logic [2:0]         rows_in_use;
  logic [COL_W-1:0]   last_col;
  logic [ROW_W-1:0]   last_row;
  clfs_pkg::mem_ctl_t mem_ctl;
  logic [ADDR_W-1:0]  frame_waddr;
  logic [7:0]         frame_wdata;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         frame_rdata;
  logic [7:0]         shadow_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= clfs_pkg::COLS_RESET;
      rows_in_use <= clfs_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clfs_pkg::REG_COLS_IN_USE: cols_in_use <= cfg_data;
        clfs_pkg::REG_ROWS_IN_USE: rows_in_use <= cfg_data[2:0];
      endcase
    end
  end

  // Sizes outside the supported range are clamped; the walk uses the last index.
  always_comb begin
    if (cols_in_use == 5'd0) begin
      last_col = '0;
    end else if (32'(cols_in_use) > MAX_COLS) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(cols_in_use - 5'd1);
    end
    if (rows_in_use == 3'd0) begin
      last_row = '0;
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(rows_in_use - 3'd1);
    end
  end

  clfs_ctrl #(
    .MAX_COLS(MAX_COLS),
    .ADDR_W  (ADDR_W),
    .COL_W   (COL_W),
    .ROW_W   (ROW_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .last_col    (last_col),
    .last_row    (last_row),
    .mem_ctl     (mem_ctl),
    .frame_waddr (frame_waddr),
    .frame_wdata (frame_wdata),
    .rd_addr     (rd_addr),
    .frame_rdata (frame_rdata),
    .shadow_rdata(shadow_rdata)
  );

  clfs_cell_mem #(
    .DEPTH (CELLS),
    .ADDR_W(ADDR_W)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .clear_all(mem_ctl.frame_clear),
    .we       (mem_ctl.frame_we),
    .waddr    (frame_waddr),
    .wdata    (frame_wdata),
    .re       (mem_ctl.frame_re),
    .raddr    (rd_addr),
    .rdata    (frame_rdata)
  );

  clfs_cell_mem #(
    .DEPTH (CELLS),
    .ADDR_W(ADDR_W)
  ) u_shadow (
    .clk      (clk),
    .rst      (rst),
    .clear_all(1'b0),
    .we       (mem_ctl.shadow_we),
    .waddr    (rd_addr),
    .wdata    (frame_rdata),
    .re       (mem_ctl.shadow_re),
    .raddr    (rd_addr),
    .rdata    (shadow_rdata)
  );

endmodule
`default_nettype wire
